// ===== hdl/imu_adc_filter_offset_calibrate_core_defines.svh =====
// ----------------------------------------------------------------------------
// IMU filter and calibration assertion macros
// Shorthand for the concurrent checks used in the block's RTL.
// ----------------------------------------------------------------------------
`ifndef IMU_ADC_FILTER_OFFSET_CALIBRATE_CORE_DEFINES_SVH
`define IMU_ADC_FILTER_OFFSET_CALIBRATE_CORE_DEFINES_SVH

// Same-cycle implication.
`define IMU_CAL_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imu_cal: same-cycle check failed");

// Next-cycle implication.
`define IMU_CAL_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imu_cal: next-cycle check failed");

`endif

// ===== hdl/imu_cal_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU filter and calibration package
// Shared widths, defaults, register indexes and filter constants.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

  localparam int NUM_OUT_CH      = 6;
  localparam int GRAVITY_CH      = 2;
  localparam int DEF_CHANNELS    = 6;
  localparam int DEF_SAMPLE_BITS = 10;

  localparam int CORR_BITS   = 12;
  localparam int COUNT_BITS  = 16;
  localparam int COUNT_LOW_BITS = 8;
  localparam int ZGRAV_BITS  = 11;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam int S12_MAX = 2047;
  localparam int S12_MIN = -2048;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [COUNT_BITS-1:0] RST_SETTLE_COUNT = 16'd500;
  localparam logic [ZGRAV_BITS-1:0] RST_Z_GRAVITY    = '0;
  localparam logic [NUM_OUT_CH-1:0] RST_SIGN_MASK    = 6'd15;

  // Filter: keep weight and divide by ten through a reciprocal, exact for
  // dividends below 2**22.
  localparam int FILTER_KEEP = 9;
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_BITS  = 20;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT = 20'd838861;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SETTLE_COUNT = 2'd0,
    REG_Z_GRAVITY    = 2'd1,
    REG_SIGN_MASK    = 2'd2
  } cfg_reg_t;

endpackage

// ===== hdl/imu_cal_sample_if.sv =====
// ----------------------------------------------------------------------------
// IMU sample channel
// One six-channel set of raw ADC samples per transaction.
// ----------------------------------------------------------------------------
interface imu_cal_sample_if #(
  parameter int SAMPLE_BITS = imu_cal_pkg::DEF_SAMPLE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_ch0;
  logic [SAMPLE_BITS-1:0] sample_ch1;
  logic [SAMPLE_BITS-1:0] sample_ch2;
  logic [SAMPLE_BITS-1:0] sample_ch3;
  logic [SAMPLE_BITS-1:0] sample_ch4;
  logic [SAMPLE_BITS-1:0] sample_ch5;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4, sample_ch5,
    output ready
  );
endinterface

// ===== hdl/imu_cal_result_if.sv =====
// ----------------------------------------------------------------------------
// IMU result channel
// Corrected channel values and calibration status per transaction.
// ----------------------------------------------------------------------------
interface imu_cal_result_if;
  logic                                          valid;
  logic                                          ready;
  logic signed [imu_cal_pkg::CORR_BITS-1:0]      corrected_ch0;
  logic signed [imu_cal_pkg::CORR_BITS-1:0]      corrected_ch1;
  logic signed [imu_cal_pkg::CORR_BITS-1:0]      corrected_ch2;
  logic signed [imu_cal_pkg::CORR_BITS-1:0]      corrected_ch3;
  logic signed [imu_cal_pkg::CORR_BITS-1:0]      corrected_ch4;
  logic signed [imu_cal_pkg::CORR_BITS-1:0]      corrected_ch5;
  logic                                          settled_pulse;
  logic                                          calibrated;
  logic [imu_cal_pkg::COUNT_LOW_BITS-1:0]        count_low;

  modport source (
    output valid, corrected_ch0, corrected_ch1, corrected_ch2, corrected_ch3,
           corrected_ch4, corrected_ch5, settled_pulse, calibrated, count_low,
    input  ready
  );
  modport sink (
    input  valid, corrected_ch0, corrected_ch1, corrected_ch2, corrected_ch3,
           corrected_ch4, corrected_ch5, settled_pulse, calibrated, count_low,
    output ready
  );
endinterface

// ===== hdl/imu_cal_cfg_if.sv =====
// ----------------------------------------------------------------------------
// IMU configuration write channel
// Register index and write data per transaction.
// ----------------------------------------------------------------------------
interface imu_cal_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [imu_cal_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [imu_cal_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hdl/imu_adc_filter_offset_calibrate_core.sv =====
// ----------------------------------------------------------------------------
// IMU ADC filter and offset calibration core
// First-order low-pass per channel, settle counter, offset capture and
// sign-corrected output.
// ----------------------------------------------------------------------------
// Each accepted sample set gives exactly one result, in the next cycle,
// from a single output register. A new set is taken in every cycle while that
// register is empty or being read, so the sustained rate is one set per cycle;
// the output handshake alone sets it. The filter divide by ten is a constant
// reciprocal multiply in the same cycle. Configuration writes are taken at
// once (ready is always high), indexes 0 settle count, 1 Z gravity, 2 sign
// mask; other indexes are ignored. SAMPLE_BITS up to 18, CHANNELS 1 to 8,
// channels from six upwards are not processed and unused ones read as zero.
`include "imu_adc_filter_offset_calibrate_core_defines.svh"

module imu_adc_filter_offset_calibrate_core #(
  parameter int CHANNELS    = imu_cal_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = imu_cal_pkg::DEF_SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst,
  imu_cal_sample_if.sink   samples,
  imu_cal_result_if.source results,
  imu_cal_cfg_if.sink      cfg
);
  import imu_cal_pkg::*;

  localparam int ACTIVE_CH = (CHANNELS < NUM_OUT_CH) ? CHANNELS : NUM_OUT_CH;
  localparam int SUM_BITS  = SAMPLE_BITS + 4;
  localparam int PROD_BITS = SUM_BITS + RECIP_BITS;
  localparam int D_BITS    = ((SAMPLE_BITS > CORR_BITS) ? SAMPLE_BITS : CORR_BITS) + 2;

  logic [SAMPLE_BITS-1:0]       held      [NUM_OUT_CH];
  logic [SAMPLE_BITS-1:0]       filt      [NUM_OUT_CH];
  logic signed [CORR_BITS-1:0]  offs      [NUM_OUT_CH];
  logic [SAMPLE_BITS-1:0]       sample_in [NUM_OUT_CH];
  logic [SAMPLE_BITS-1:0]       filt_next [NUM_OUT_CH];
  logic signed [CORR_BITS-1:0]  offs_next [NUM_OUT_CH];
  logic signed [CORR_BITS-1:0]  corr_next [NUM_OUT_CH];
  logic signed [CORR_BITS-1:0]  corr_q    [NUM_OUT_CH];

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  captured;
  logic                  capture;
  logic                  accept;
  logic                  out_valid;
  logic                  pulse_q;
  logic                  cal_q;
  logic [COUNT_LOW_BITS-1:0] count_low_q;

  logic [COUNT_BITS-1:0]        settle_count;
  logic signed [ZGRAV_BITS-1:0] z_gravity;
  logic [NUM_OUT_CH-1:0]        sign_mask;

  function automatic logic signed [CORR_BITS-1:0] sat_corr(input logic signed [D_BITS-1:0] v);
    if (v > D_BITS'(S12_MAX)) return CORR_BITS'(S12_MAX);
    if (v < D_BITS'(S12_MIN)) return CORR_BITS'(S12_MIN);
    return v[CORR_BITS-1:0];
  endfunction

  assign sample_in[0] = samples.sample_ch0;
  assign sample_in[1] = samples.sample_ch1;
  assign sample_in[2] = samples.sample_ch2;
  assign sample_in[3] = samples.sample_ch3;
  assign sample_in[4] = samples.sample_ch4;
  assign sample_in[5] = samples.sample_ch5;

  assign samples.ready = !out_valid || results.ready;
  assign accept        = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  assign count_next = (count == COUNT_MAX) ? count : count + 1'b1;
  assign capture    = (count != COUNT_MAX) && (count_next == settle_count);

  for (genvar c = 0; c < NUM_OUT_CH; c++) begin : g_ch
    if (c < ACTIVE_CH) begin : g_act
      logic [SUM_BITS-1:0]        sum;
      logic [PROD_BITS-1:0]       prod;
      logic signed [D_BITS-1:0]   offs_raw;
      logic signed [D_BITS-1:0]   diff;
      logic signed [D_BITS-1:0]   corr_raw;
      logic signed [CORR_BITS-1:0] offs_use;

      always_comb begin
        sum  = SUM_BITS'(filt[c]) + SUM_BITS'(FILTER_KEEP) * SUM_BITS'(held[c]);
        prod = PROD_BITS'(sum) * PROD_BITS'(RECIP_MULT);
        filt_next[c] = prod[RECIP_SHIFT +: SAMPLE_BITS];
        if (c == GRAVITY_CH) begin
          offs_raw = $signed(D_BITS'(filt_next[c])) + D_BITS'(z_gravity);
        end else begin
          offs_raw = $signed(D_BITS'(filt_next[c]));
        end
        offs_use     = capture ? sat_corr(offs_raw) : offs[c];
        offs_next[c] = offs_use;
        diff         = $signed(D_BITS'(filt_next[c])) - D_BITS'(offs_use);
        corr_raw     = sign_mask[c] ? -diff : diff;
        corr_next[c] = sat_corr(corr_raw);
      end
    end else begin : g_idle
      assign filt_next[c] = filt[c];
      assign offs_next[c] = offs[c];
      assign corr_next[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_OUT_CH; c++) begin
        held[c] <= '0;
        filt[c] <= '0;
        offs[c] <= '0;
      end
      count        <= '0;
      captured     <= 1'b0;
      out_valid    <= 1'b0;
      settle_count <= RST_SETTLE_COUNT;
      z_gravity    <= RST_Z_GRAVITY;
      sign_mask    <= RST_SIGN_MASK;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SETTLE_COUNT: settle_count <= cfg.data[COUNT_BITS-1:0];
          REG_Z_GRAVITY:    z_gravity    <= cfg.data[ZGRAV_BITS-1:0];
          REG_SIGN_MASK:    sign_mask    <= cfg.data[NUM_OUT_CH-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        for (int c = 0; c < NUM_OUT_CH; c++) begin
          held[c] <= sample_in[c];
          filt[c] <= filt_next[c];
          offs[c] <= offs_next[c];
        end
        count    <= count_next;
        captured <= captured || capture;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      corr_q      <= corr_next;
      pulse_q     <= capture;
      cal_q       <= captured || capture;
      count_low_q <= count_next[COUNT_LOW_BITS-1:0];
    end
  end

  assign results.valid         = out_valid;
  assign results.corrected_ch0 = corr_q[0];
  assign results.corrected_ch1 = corr_q[1];
  assign results.corrected_ch2 = corr_q[2];
  assign results.corrected_ch3 = corr_q[3];
  assign results.corrected_ch4 = corr_q[4];
  assign results.corrected_ch5 = corr_q[5];
  assign results.settled_pulse = pulse_q;
  assign results.calibrated    = cal_q;
  assign results.count_low     = count_low_q;

  `IMU_CAL_ASSERT_NEXT(a_accept_gives_result, clk, rst, accept, out_valid)
  `IMU_CAL_ASSERT_IMPLIES(a_pulse_means_cal, clk, rst, out_valid && pulse_q, cal_q)
  `IMU_CAL_ASSERT_NEXT(a_sat_never_captures, clk, rst, accept && count == COUNT_MAX, !pulse_q && count == COUNT_MAX)
  `IMU_CAL_ASSERT_NEXT(a_capture_sets_flag, clk, rst, accept && capture, captured && pulse_q)

endmodule
